/* hdl/fft_twiddle_factor_generator_unit_defines.svh */
// Assertion macros shared by the twiddle generator RTL.
`ifndef FFT_TWIDDLE_FACTOR_GENERATOR_UNIT_DEFINES_SVH
`define FFT_TWIDDLE_FACTOR_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FTG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FTG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ftg_pkg.sv */
// Shared types, constants and register codes of the twiddle generator.
package ftg_pkg;

  // field widths
  localparam int unsigned STAGE_W    = 4;
  localparam int unsigned INDEX_W    = 15;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned MULT_W     = 3;
  localparam int unsigned SLOT_W     = 16;
  localparam int unsigned RADIX_W    = 2;
  localparam int unsigned SIZE_W     = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2  = 2'd1;

  localparam logic [RADIX_W-1:0] RADIX_LOG2_RESET = 2'd1;
  localparam logic [SIZE_W-1:0]  SIZE_LOG2_RESET  = 5'd10;

  // build constants
  localparam int unsigned PHASE_BITS    = 16;
  localparam int unsigned OUT_BITS      = 16;
  localparam int unsigned MAX_SIZE_LOG2 = 16;

  // internal widths
  localparam int unsigned LK_W  = 6;                  // log2(k), up to 3*15+3
  localparam int unsigned NUM_W = INDEX_W + MULT_W;   // m*j
  localparam int unsigned FRAC  = 30;
  localparam int unsigned X_W   = 30;                 // angle and x^2, Q.30 below 1.0
  localparam int unsigned T_W   = 31;                 // series terms, up to 1.0 in Q.30

  localparam logic [T_W-1:0] ONE_Q = T_W'(1) << FRAC;

  // 2*pi in Q.40, split for two narrow multipliers
  localparam logic [63:0]    TWO_PI_Q40 = 64'd6908435304715;
  localparam int unsigned    C_SPLIT    = 22;
  localparam int unsigned    C_LO_W     = 22;
  localparam int unsigned    C_HI_W     = 21;
  localparam logic [C_HI_W-1:0] C_HI = C_HI_W'(TWO_PI_Q40 >> C_SPLIT);
  localparam logic [C_LO_W-1:0] C_LO = C_LO_W'(TWO_PI_Q40);

  // Horner divisors, innermost term last
  localparam int unsigned N_STEPS  = 6;
  localparam int unsigned DEN_W    = 8;
  localparam int unsigned RECIP_W  = 31;
  localparam int unsigned RECIP_SH = 31;
  localparam int unsigned SIN_DEN [N_STEPS] = '{6, 20, 42, 72, 110, 156};
  localparam int unsigned COS_DEN [N_STEPS] = '{2, 12, 30, 56, 90, 132};

  typedef struct packed {
    logic [STAGE_W-1:0] stage;
    logic [INDEX_W-1:0] index;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] cos_val;
    logic signed [VAL_W-1:0] sin_val;
    logic [MULT_W-1:0]       multiplier;
    logic [SLOT_W-1:0]       slot;
    logic                    error;
    logic                    last;
  } out_item_t;

  // effective configuration after the special-case mapping
  typedef struct packed {
    logic [RADIX_W-1:0] radix_log2;
    logic [SIZE_W-1:0]  size_log2;
  } cfg_t;

  // sideband that rides along with each twiddle
  typedef struct packed {
    logic [MULT_W-1:0] mult;
    logic [SLOT_W-1:0] slot;
    logic              err;
    logic              last;
    logic [1:0]        quad;
    logic              swap;
  } tag_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [LK_W-1:0]    lk;
    tag_t               tag;
  } issue_t;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [X_W-1:0] x2;
    logic [T_W-1:0] ts;
    logic [T_W-1:0] tc;
    tag_t           tag;
  } horner_t;

endpackage

/* hdl/ftg_issue.sv */
// Issue stage: holds one input item and steps the multiplier m once per cycle while the output is ready.
module ftg_issue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ftg_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ftg_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ftg_pkg::issue_t    out_data_o
);

  logic                                hold_q;
  logic [ftg_pkg::INDEX_W-1:0]         index_q;
  logic [ftg_pkg::LK_W-1:0]            lell_q, lell_d;
  logic [ftg_pkg::RADIX_W-1:0]         rl_q;
  logic                                err_q, err_d;
  logic [ftg_pkg::MULT_W-1:0]          mult_q, mult_last_q, mult_last_d;
  logic                                last;
  logic                                done;
  logic                                take;

  // stage check: q >= ceil(sl/rl) is the same as rl*q >= sl
  always_comb begin
    lell_d = ftg_pkg::LK_W'(cfg_i.radix_log2) * ftg_pkg::LK_W'(in_data_i.stage);
    err_d  = (lell_d >= ftg_pkg::LK_W'(cfg_i.size_log2)) ||
             ((lell_d < ftg_pkg::LK_W'(ftg_pkg::INDEX_W)) &&
              ((in_data_i.index >> lell_d) != '0));
    mult_last_d = ftg_pkg::MULT_W'((4'd1 << cfg_i.radix_log2) - 4'd1);
  end

  assign last        = err_q || (mult_q == mult_last_q);
  assign done        = hold_q && out_ready_i && last;
  assign in_ready_o  = !hold_q || done;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = hold_q;

  always_comb begin
    out_data_o.index    = index_q;
    out_data_o.lk       = lell_q + ftg_pkg::LK_W'(rl_q);
    out_data_o.tag.mult = err_q ? '0 : mult_q;
    out_data_o.tag.slot = err_q ? '0 :
      ftg_pkg::SLOT_W'(index_q) + (ftg_pkg::SLOT_W'(mult_q - 3'd1) << lell_q);
    out_data_o.tag.err  = err_q;
    out_data_o.tag.last = last;
    out_data_o.tag.quad = '0;
    out_data_o.tag.swap = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else if (take) begin
      hold_q <= 1'b1;
    end else if (done) begin
      hold_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      index_q     <= in_data_i.index;
      lell_q      <= lell_d;
      rl_q        <= cfg_i.radix_log2;
      err_q       <= err_d;
      mult_q      <= ftg_pkg::MULT_W'(1);
      mult_last_q <= mult_last_d;
    end else if (hold_q && out_ready_i) begin
      mult_q <= mult_q + 3'd1;
    end
  end

endmodule

/* hdl/ftg_angle.sv */
// Phase, octant fold and reduced angle x with x^2, four register stages.
module ftg_angle #(
  parameter int unsigned PhaseBits = ftg_pkg::PHASE_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ftg_pkg::issue_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ftg_pkg::horner_t  out_data_o
);

  localparam int unsigned PW   = PhaseBits;
  localparam int unsigned RW   = PhaseBits - 2;
  localparam int unsigned HiW  = RW + ftg_pkg::C_HI_W;
  localparam int unsigned LoW  = RW + ftg_pkg::C_LO_W;
  localparam int unsigned SumW = RW + ftg_pkg::C_SPLIT + ftg_pkg::C_HI_W + 1;
  localparam int unsigned RndW = ftg_pkg::NUM_W + 1;
  localparam int unsigned SqW  = 2 * ftg_pkg::X_W;
  localparam int unsigned XSh  = PhaseBits + 10;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [PW-1:0]             p1_q, p_d;
  ftg_pkg::tag_t             tag1_q, tag2_q, tag2_d, tag3_q, tag4_q;
  logic [HiW-1:0]            hi2_q, hi_d;
  logic [LoW-1:0]            lo2_q, lo_d;
  logic [ftg_pkg::X_W-1:0]   x3_q, x_d, x4_q, x2_4_q, x2_d;

  logic [ftg_pkg::NUM_W-1:0] num;
  logic [ftg_pkg::LK_W-1:0]  lsh, rsh;
  logic [RndW-1:0]           rnd;
  logic [1:0]                quad;
  logic [RW-1:0]             r, r_f;
  logic                      fold;
  logic [SumW-1:0]           sum;
  logic [SqW-1:0]            sq;

  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // stage 1: turn fraction m*j/k as a PW-bit phase, rounded half up when k is finer
  always_comb begin
    num = ftg_pkg::NUM_W'(in_data_i.tag.mult) * ftg_pkg::NUM_W'(in_data_i.index);
    lsh = ftg_pkg::LK_W'(PW) - in_data_i.lk;
    rsh = in_data_i.lk - ftg_pkg::LK_W'(PW);
    rnd = RndW'(num) + (RndW'(1) << (rsh - ftg_pkg::LK_W'(1)));
    if (in_data_i.lk <= ftg_pkg::LK_W'(PW)) begin
      p_d = PW'(num) << lsh;
    end else if (rsh > ftg_pkg::LK_W'(ftg_pkg::NUM_W)) begin
      p_d = '0;
    end else begin
      p_d = PW'(rnd >> rsh);
    end
  end

  // stage 2: fold into the first octant, then r * 2pi in two partial products
  always_comb begin
    quad   = p1_q[PW-1 -: 2];
    r      = p1_q[RW-1:0];
    fold   = r > (RW'(1) << (RW - 1));
    r_f    = fold ? (RW'(0) - r) : r;
    hi_d   = HiW'(r_f) * HiW'(ftg_pkg::C_HI);
    lo_d   = LoW'(r_f) * LoW'(ftg_pkg::C_LO);
    tag2_d = tag1_q;
    tag2_d.quad = quad;
    tag2_d.swap = fold;
  end

  // stage 3: join partial products, x in Q.30
  always_comb begin
    sum = (SumW'(hi2_q) << ftg_pkg::C_SPLIT) + SumW'(lo2_q);
    x_d = ftg_pkg::X_W'(sum >> XSh);
  end

  // stage 4: x^2
  always_comb begin
    sq   = SqW'(x3_q) * SqW'(x3_q);
    x2_d = ftg_pkg::X_W'(sq >> ftg_pkg::FRAC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      p1_q   <= p_d;
      tag1_q <= in_data_i.tag;
    end
    if (rdy2 && v1_q) begin
      hi2_q  <= hi_d;
      lo2_q  <= lo_d;
      tag2_q <= tag2_d;
    end
    if (rdy3 && v2_q) begin
      x3_q   <= x_d;
      tag3_q <= tag2_q;
    end
    if (rdy4 && v3_q) begin
      x4_q   <= x3_q;
      x2_4_q <= x2_d;
      tag4_q <= tag3_q;
    end
  end

  assign out_valid_o   = v4_q;
  assign out_data_o.x  = x4_q;
  assign out_data_o.x2 = x2_4_q;
  assign out_data_o.ts = ftg_pkg::ONE_Q;
  assign out_data_o.tc = ftg_pkg::ONE_Q;
  assign out_data_o.tag = tag4_q;

endmodule

/* hdl/ftg_horner.sv */
// One Horner step of the sine and cosine series, three register stages.
module ftg_horner #(
  parameter int unsigned Step = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ftg_pkg::horner_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ftg_pkg::horner_t  out_data_o
);

  localparam int unsigned Idx   = ftg_pkg::N_STEPS - 1 - Step;
  localparam int unsigned ProdW = ftg_pkg::X_W + ftg_pkg::T_W;
  localparam int unsigned MulW  = ftg_pkg::X_W + ftg_pkg::RECIP_W;
  localparam int unsigned ChkW  = ftg_pkg::X_W + ftg_pkg::DEN_W;
  localparam logic [ftg_pkg::DEN_W-1:0] SinD = ftg_pkg::DEN_W'(ftg_pkg::SIN_DEN[Idx]);
  localparam logic [ftg_pkg::DEN_W-1:0] CosD = ftg_pkg::DEN_W'(ftg_pkg::COS_DEN[Idx]);
  localparam logic [ftg_pkg::RECIP_W-1:0] SinM =
    ftg_pkg::RECIP_W'((64'd1 << ftg_pkg::RECIP_SH) / ftg_pkg::SIN_DEN[Idx]);
  localparam logic [ftg_pkg::RECIP_W-1:0] CosM =
    ftg_pkg::RECIP_W'((64'd1 << ftg_pkg::RECIP_SH) / ftg_pkg::COS_DEN[Idx]);

  // reciprocal quotient is exact or one low; fix it and form 1 - v/d
  function automatic logic [ftg_pkg::T_W-1:0] next_term(
    input logic [ftg_pkg::X_W-1:0]   v,
    input logic [ftg_pkg::X_W-1:0]   q0,
    input logic [ftg_pkg::DEN_W-1:0] d
  );
    logic [ftg_pkg::X_W-1:0] q_inc;
    logic [ftg_pkg::X_W-1:0] q;
    q_inc = q0 + ftg_pkg::X_W'(1);
    q     = (ChkW'(v) >= ChkW'(q_inc) * ChkW'(d)) ? q_inc : q0;
    return ftg_pkg::ONE_Q - ftg_pkg::T_W'(q);
  endfunction

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  ftg_pkg::horner_t        node1_q, node2_q, node3_q, node3_d;
  logic [ftg_pkg::X_W-1:0] vs1_q, vc1_q, vs_d, vc_d;
  logic [ftg_pkg::X_W-1:0] vs2_q, vc2_q, qs2_q, qc2_q, qs_d, qc_d;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_comb begin
    vs_d = ftg_pkg::X_W'((ProdW'(in_data_i.x2) * ProdW'(in_data_i.ts)) >> ftg_pkg::FRAC);
    vc_d = ftg_pkg::X_W'((ProdW'(in_data_i.x2) * ProdW'(in_data_i.tc)) >> ftg_pkg::FRAC);
    qs_d = ftg_pkg::X_W'((MulW'(vs1_q) * MulW'(SinM)) >> ftg_pkg::RECIP_SH);
    qc_d = ftg_pkg::X_W'((MulW'(vc1_q) * MulW'(CosM)) >> ftg_pkg::RECIP_SH);
    node3_d    = node2_q;
    node3_d.ts = next_term(vs2_q, qs2_q, SinD);
    node3_d.tc = next_term(vc2_q, qc2_q, CosD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      node1_q <= in_data_i;
      vs1_q   <= vs_d;
      vc1_q   <= vc_d;
    end
    if (rdy2 && v1_q) begin
      node2_q <= node1_q;
      vs2_q   <= vs1_q;
      vc2_q   <= vc1_q;
      qs2_q   <= qs_d;
      qc2_q   <= qc_d;
    end
    if (rdy3 && v2_q) begin
      node3_q <= node3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = node3_q;

endmodule

/* hdl/ftg_finish.sv */
// Final sine product, quadrant mapping, rounding and the output register.
module ftg_finish (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ftg_pkg::horner_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ftg_pkg::out_item_t out_data_o
);

  localparam int unsigned ProdW = ftg_pkg::X_W + ftg_pkg::T_W;
  localparam int unsigned OutSh = ftg_pkg::FRAC - (ftg_pkg::OUT_BITS - 1);
  localparam logic [31:0] RoundHalf = 32'd1 << (OutSh - 1);
  localparam logic [31:0] MaxPos    = (32'd1 << (ftg_pkg::OUT_BITS - 1)) - 32'd1;

  // round half up on magnitude, apply sign, clamp +1.0
  function automatic logic [ftg_pkg::VAL_W-1:0] to_out(
    input logic [ftg_pkg::T_W-1:0] mag,
    input logic                    neg
  );
    logic [31:0] v;
    v = (32'(mag) + RoundHalf) >> OutSh;
    if (neg) return ftg_pkg::VAL_W'(32'd0 - v);
    if (v > MaxPos) v = MaxPos;
    return ftg_pkg::VAL_W'(v);
  endfunction

  logic v1_q, v2_q;
  logic rdy1, rdy2;

  logic [ftg_pkg::T_W-1:0] s0_q, s0_d, c0_q;
  ftg_pkg::tag_t           tag1_q;
  ftg_pkg::out_item_t      out_q, out_d;

  logic [ftg_pkg::T_W-1:0] s_f, c_f, cm, sm;
  logic                    cneg, sneg;

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign s0_d = ftg_pkg::T_W'((ProdW'(in_data_i.x) * ProdW'(in_data_i.ts)) >> ftg_pkg::FRAC);

  always_comb begin
    s_f = tag1_q.swap ? c0_q : s0_q;
    c_f = tag1_q.swap ? s0_q : c0_q;
    // imaginary part carries -sin of the phase
    case (tag1_q.quad)
      2'd0:    begin cm = c_f; cneg = 1'b0; sm = s_f; sneg = 1'b1; end
      2'd1:    begin cm = s_f; cneg = 1'b1; sm = c_f; sneg = 1'b1; end
      2'd2:    begin cm = c_f; cneg = 1'b1; sm = s_f; sneg = 1'b0; end
      default: begin cm = s_f; cneg = 1'b0; sm = c_f; sneg = 1'b0; end
    endcase
    out_d.cos_val    = tag1_q.err ? '0 : $signed(to_out(cm, cneg));
    out_d.sin_val    = tag1_q.err ? '0 : $signed(to_out(sm, sneg));
    out_d.multiplier = tag1_q.mult;
    out_d.slot       = tag1_q.slot;
    out_d.error      = tag1_q.err;
    out_d.last       = tag1_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s0_q   <= s0_d;
      c0_q   <= in_data_i.tc;
      tag1_q <= in_data_i.tag;
    end
    if (rdy2 && v1_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/fft_twiddle_factor_generator_unit.sv */
// Top level of the FFT twiddle generator: config registers and the twiddle pipeline.
// Path: an item is registered in the issue stage, then passes the angle stages, the Horner
//   steps and the finish registers; the results of an item leave in order of m.
// Throughput: one result per cycle when the output is not stalled; an item yields radix-1
//   results (1 when flagged as an error) from the issue stage, which steps m once per cycle.
// Reset: async, active low; clears all valid bits, radix_log2 to 1 and size_log2 to 10.
`include "fft_twiddle_factor_generator_unit_defines.svh"

module fft_twiddle_factor_generator_unit #(
  parameter int unsigned PhaseBits = ftg_pkg::PHASE_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ftg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ftg_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ftg_pkg::in_item_t                 in_data_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output ftg_pkg::out_item_t                out_data_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; unknown indexes are dropped.
  // ---------------------------------------------------------------------------
  logic [ftg_pkg::RADIX_W-1:0] radix_q;
  logic [ftg_pkg::SIZE_W-1:0]  size_q;
  ftg_pkg::cfg_t               cfg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= ftg_pkg::RADIX_LOG2_RESET;
      size_q  <= ftg_pkg::SIZE_LOG2_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ftg_pkg::REG_RADIX_LOG2: radix_q <= cfg_data_i[ftg_pkg::RADIX_W-1:0];
        ftg_pkg::REG_SIZE_LOG2:  size_q  <= cfg_data_i[ftg_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Radix code zero behaves as radix 2; the length is capped at the largest supported size.
  assign cfg.radix_log2 = (radix_q == '0) ? ftg_pkg::RADIX_W'(1) : radix_q;
  assign cfg.size_log2  = (size_q > ftg_pkg::SIZE_W'(ftg_pkg::MAX_SIZE_LOG2)) ?
                          ftg_pkg::SIZE_W'(ftg_pkg::MAX_SIZE_LOG2) : size_q;

  // ---------------------------------------------------------------------------
  // Issue: range check, then one token per multiplier m = 1..radix-1 (a single token on error).
  // ---------------------------------------------------------------------------
  logic             iss_valid, iss_ready;
  ftg_pkg::issue_t  iss_data;

  ftg_issue u_issue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (iss_valid),
    .out_ready_i (iss_ready),
    .out_data_o  (iss_data)
  );

  // ---------------------------------------------------------------------------
  // Angle: phase of m*j/k, octant fold, x = 2*pi*r in Q.30 and x^2 (4 stages).
  // ---------------------------------------------------------------------------
  logic [ftg_pkg::N_STEPS:0] hv, hr;
  ftg_pkg::horner_t          hn [ftg_pkg::N_STEPS+1];

  ftg_angle #(
    .PhaseBits (PhaseBits)
  ) u_angle (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (iss_valid),
    .in_ready_o  (iss_ready),
    .in_data_i   (iss_data),
    .out_valid_o (hv[0]),
    .out_ready_i (hr[0]),
    .out_data_o  (hn[0])
  );

  // ---------------------------------------------------------------------------
  // Six Horner steps, sine and cosine side by side, 3 stages each.
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < ftg_pkg::N_STEPS; g++) begin : g_step
    ftg_horner #(
      .Step (g)
    ) u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (hv[g]),
      .in_ready_o  (hr[g]),
      .in_data_i   (hn[g]),
      .out_valid_o (hv[g+1]),
      .out_ready_i (hr[g+1]),
      .out_data_o  (hn[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Finish: sin = x * series, quadrant signs, Q1.15 rounding, output register.
  // ---------------------------------------------------------------------------
  ftg_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (hv[ftg_pkg::N_STEPS]),
    .in_ready_o  (hr[ftg_pkg::N_STEPS]),
    .in_data_i   (hn[ftg_pkg::N_STEPS]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  logic [ftg_pkg::MULT_W-1:0] mult_last;
  assign mult_last = ftg_pkg::MULT_W'((4'd1 << cfg.radix_log2) - 4'd1);

  `FTG_ASSERT_IMP(a_err_result_clean, out_valid_o && out_data_o.error,
    out_data_o.last && (out_data_o.multiplier == '0) && (out_data_o.cos_val == '0) &&
    (out_data_o.sin_val == '0), "error result not a lone zeroed item")
  `FTG_ASSERT_IMP(a_last_mult, out_valid_o && !out_data_o.error && out_data_o.last,
    out_data_o.multiplier == mult_last, "last twiddle multiplier is not radix-1")
  `FTG_ASSERT_NXT(a_issue_loaded, in_valid_i && in_ready_o, iss_valid,
    "issue stage empty after input transfer")

endmodule
